[sv/dba_pkg.sv]
// shared types, constants and command codes of the double-ended bump allocator
package dba_pkg;

  localparam int ADDR_WIDTH  = 32;
  localparam int DATA_W      = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CALC_W      = 35;

  localparam logic [1:0] CMD_ALLOC     = 2'd0;
  localparam logic [1:0] CMD_FREE_ALL  = 2'd1;
  localparam logic [1:0] CMD_FREE_TAIL = 2'd2;
  localparam logic [1:0] CMD_QUERY     = 2'd3;

  localparam logic REG_HEAP_START = 1'b0;
  localparam logic REG_HEAP_BYTES = 1'b1;

  localparam logic [DATA_W-1:0] MIN_UNIT  = 32'd4;
  localparam logic [4:0]        MIN_ALIGN = 5'd2;

  typedef struct packed {
    logic [DATA_W-1:0] heap_start;
    logic [DATA_W-1:0] heap_bytes;
  } dba_cfg_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [DATA_W-1:0] req_bytes;
    logic [4:0]        align_log2;
    logic              from_tail;
  } dba_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] block_addr;
    logic              ok;
    logic [DATA_W-1:0] free_bytes;
    logic [DATA_W-1:0] head_used;
    logic [DATA_W-1:0] tail_used;
    logic [DATA_W-1:0] check_code;
  } dba_rsp_t;

endpackage

[sv/dba_if.sv]
// request and result channel interfaces
interface dba_req_if
  import dba_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic [DATA_W-1:0]   req_bytes;
  logic [4:0]          align_log2;
  logic                from_tail;

  modport source(output valid, cmd, req_bytes, align_log2, from_tail, input ready);
  modport sink(input valid, cmd, req_bytes, align_log2, from_tail, output ready);
endinterface

interface dba_rsp_if
  import dba_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   block_addr;
  logic                ok;
  logic [DATA_W-1:0]   free_bytes;
  logic [DATA_W-1:0]   head_used;
  logic [DATA_W-1:0]   tail_used;
  logic [DATA_W-1:0]   check_code;

  modport source(output valid, block_addr, ok, free_bytes, head_used, tail_used,
                 check_code, input ready);
  modport sink(input valid, block_addr, ok, free_bytes, head_used, tail_used,
               check_code, output ready);
endinterface

[sv/dba_cfg_regs.sv]
// apb configuration registers for region start and size
module dba_cfg_regs
  import dba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  output dba_cfg_t              cfg
);

  dba_cfg_t cfg_r;
  dba_cfg_t cfg_nxt;
  logic     wr_en;
  logic     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_HEAP_START: cfg_nxt.heap_start = pwdata;
        REG_HEAP_BYTES: cfg_nxt.heap_bytes = pwdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HEAP_START: prdata = cfg_r.heap_start;
      REG_HEAP_BYTES: prdata = cfg_r.heap_bytes;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/dba_core.sv]
// single-pass allocate, free and query datapath
module dba_core
  import dba_pkg::*;
(
  input  dba_cfg_t          cfg,
  input  logic [DATA_W-1:0] head_count,
  input  logic [DATA_W-1:0] tail_count,
  input  dba_req_t          req,
  output dba_rsp_t          rsp
);

  logic [DATA_W:0]   region_end;
  logic [DATA_W:0]   head_addr;
  logic [DATA_W:0]   tail_addr;
  logic [DATA_W:0]   used_now;
  logic [DATA_W-1:0] free_now;
  logic [DATA_W:0]   size_raw;
  logic [DATA_W:0]   size_rnd;
  logic [4:0]        lg;
  logic [CALC_W-1:0] align_m1;
  logic [CALC_W-1:0] blk_h;
  logic [CALC_W-1:0] total_h;
  logic [CALC_W-1:0] blk_t;
  logic [CALC_W-1:0] total_t;
  logic [CALC_W-1:0] blk;
  logic [CALC_W-1:0] total;
  logic              range_ok;
  logic              tail_bad;
  logic              alloc_ok;
  logic [DATA_W-1:0] head_new;
  logic [DATA_W-1:0] tail_new;
  logic [DATA_W-1:0] ha_now;
  logic [DATA_W-1:0] ta_now;
  logic [DATA_W-1:0] ta_base;
  logic [DATA_W-1:0] ha_head;
  logic [DATA_W-1:0] free_tail;
  logic [DATA_W-1:0] chk_now;
  logic [DATA_W-1:0] chk_head;
  logic [DATA_W-1:0] chk_tail;
  logic [DATA_W-1:0] chk_all;
  logic [DATA_W-1:0] chk_ftail;

  function automatic logic [DATA_W-1:0] chk_sum(input logic [DATA_W-1:0] h,
                                                input logic [DATA_W-1:0] t);
    return h + {t[DATA_W-2:0], 1'b0} + t;
  endfunction

  always_comb begin
    region_end = {1'b0, cfg.heap_start} + {1'b0, cfg.heap_bytes};
    head_addr  = {1'b0, cfg.heap_start} + {1'b0, head_count};
    tail_addr  = region_end - {1'b0, tail_count};
    used_now   = {1'b0, head_count} + {1'b0, tail_count};
    free_now   = (used_now > {1'b0, cfg.heap_bytes}) ? '0
               : cfg.heap_bytes - used_now[DATA_W-1:0];
    free_tail  = (head_count > cfg.heap_bytes) ? '0 : cfg.heap_bytes - head_count;
    range_ok   = (65'(region_end) <= (65'(1) << ADDR_WIDTH));

    lg       = (req.align_log2 < MIN_ALIGN) ? MIN_ALIGN : req.align_log2;
    align_m1 = (CALC_W'(1) << lg) - CALC_W'(1);
    size_raw = (req.req_bytes < MIN_UNIT) ? {1'b0, MIN_UNIT} : {1'b0, req.req_bytes};
    size_rnd = (size_raw + (DATA_W+1)'(3)) & ~(DATA_W+1)'(3);

    // head aligns up, tail aligns down
    blk_h   = (CALC_W'(head_addr) + align_m1) & ~align_m1;
    total_h = CALC_W'(size_rnd) + (blk_h - CALC_W'(head_addr));
    tail_bad = ({1'b0, tail_count} > region_end) || (size_rnd > tail_addr);
    blk_t   = (CALC_W'(tail_addr) - CALC_W'(size_rnd)) & ~align_m1;
    total_t = CALC_W'(tail_addr) - blk_t;

    blk      = req.from_tail ? blk_t : blk_h;
    total    = req.from_tail ? total_t : total_h;
    alloc_ok = range_ok && !(req.from_tail && tail_bad) && (total <= CALC_W'(free_now));

    // end addresses for every outcome, evaluated side by side
    ha_now    = head_addr[DATA_W-1:0];
    ta_now    = tail_addr[DATA_W-1:0];
    ta_base   = region_end[DATA_W-1:0];
    ha_head   = blk_h[DATA_W-1:0] + size_rnd[DATA_W-1:0];
    chk_now   = chk_sum(ha_now, ta_now);
    chk_head  = chk_sum(ha_head, ta_now);
    chk_tail  = chk_sum(ha_now, blk_t[DATA_W-1:0]);
    chk_all   = chk_sum(cfg.heap_start, ta_base);
    chk_ftail = chk_sum(ha_now, ta_base);

    head_new       = head_count;
    tail_new       = tail_count;
    rsp.block_addr = '0;
    rsp.ok         = 1'b1;
    rsp.free_bytes = free_now;
    rsp.check_code = chk_now;
    case (req.cmd)
      CMD_ALLOC: begin
        rsp.ok = alloc_ok;
        if (alloc_ok) begin
          rsp.block_addr = blk[DATA_W-1:0];
          rsp.free_bytes = free_now - total[DATA_W-1:0];
          if (req.from_tail) begin
            tail_new       = tail_count + total[DATA_W-1:0];
            rsp.check_code = chk_tail;
          end else begin
            head_new       = head_count + total[DATA_W-1:0];
            rsp.check_code = chk_head;
          end
        end
      end
      CMD_FREE_ALL: begin
        head_new       = '0;
        tail_new       = '0;
        rsp.free_bytes = cfg.heap_bytes;
        rsp.check_code = chk_all;
      end
      CMD_FREE_TAIL: begin
        tail_new       = '0;
        rsp.free_bytes = free_tail;
        rsp.check_code = chk_ftail;
      end
      CMD_QUERY: begin
        rsp.ok = 1'b1;
      end
      default: begin
        rsp.ok = 1'b1;
      end
    endcase

    rsp.head_used = head_new;
    rsp.tail_used = tail_new;
  end

endmodule

[sv/double_ended_bump_allocator.sv]
// top level: request register, allocator datapath, count state and result register
//
//  port      dir   kind         contents
//  in_req    in    valid/ready  cmd, req_bytes, align_log2, from_tail
//  out_rsp   out   valid/ready  block_addr, ok, free_bytes, head_used, tail_used, check_code
//  psel..    in    apb          heap_start at 0x0, heap_bytes at 0x4
//
// one request per cycle unless out_rsp stalls; requests and results are both registered
// the head and tail counts and the datapath form a loop closed by the count registers, so the next
// request already sees the counts left by this one
// synchronous active-low reset clears counts, configuration and both valid flags
// a stalled output holds its result while one more request waits in the input register
module double_ended_bump_allocator
  import dba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  dba_req_if.sink               in_req,
  dba_rsp_if.source             out_rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  dba_cfg_t          cfg;
  dba_req_t          req_r;
  logic              req_v_r;
  dba_rsp_t          rsp_nxt;
  dba_rsp_t          rsp_r;
  logic              rsp_v_r;
  logic [DATA_W-1:0] head_r;
  logic [DATA_W-1:0] tail_r;
  logic              adv;
  logic              in_fire;

  dba_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dba_core u_core (
    .cfg        (cfg),
    .head_count (head_r),
    .tail_count (tail_r),
    .req        (req_r),
    .rsp        (rsp_nxt)
  );

  assign adv          = req_v_r & (~rsp_v_r | out_rsp.ready);
  assign in_req.ready = ~req_v_r | adv;
  assign in_fire      = in_req.valid & in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      rsp_v_r <= 1'b0;
      head_r  <= '0;
      tail_r  <= '0;
    end else begin
      if (in_fire) begin
        req_v_r <= 1'b1;
      end else if (adv) begin
        req_v_r <= 1'b0;
      end
      if (adv) begin
        rsp_v_r <= 1'b1;
        head_r  <= rsp_nxt.head_used;
        tail_r  <= rsp_nxt.tail_used;
      end else if (out_rsp.ready) begin
        rsp_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.cmd        <= in_req.cmd;
      req_r.req_bytes  <= in_req.req_bytes;
      req_r.align_log2 <= in_req.align_log2;
      req_r.from_tail  <= in_req.from_tail;
    end
    if (adv) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_rsp.valid      = rsp_v_r;
  assign out_rsp.block_addr = rsp_r.block_addr;
  assign out_rsp.ok         = rsp_r.ok;
  assign out_rsp.free_bytes = rsp_r.free_bytes;
  assign out_rsp.head_used  = rsp_r.head_used;
  assign out_rsp.tail_used  = rsp_r.tail_used;
  assign out_rsp.check_code = rsp_r.check_code;

  a_fail_keeps_counts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !rsp_nxt.ok |=> head_r == $past(head_r) && tail_r == $past(tail_r))
    else $error("failed allocation changed the counts");

  a_free_all_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && req_r.cmd == CMD_FREE_ALL |=> head_r == '0 && tail_r == '0)
    else $error("free all left counts behind");

  a_non_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    adv && req_r.cmd != CMD_ALLOC |=> out_rsp.valid && out_rsp.ok
      && out_rsp.block_addr == '0)
    else $error("non-allocate request reported a failure or an address");

  a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
    req_v_r && !adv |=> req_v_r && $stable(req_r))
    else $error("waiting request lost");

endmodule

[tb/double_ended_bump_allocator_test.sv]
// testbench for the double-ended bump allocator: directed and random requests against a predictor
`timescale 1ns / 100ps

module double_ended_bump_allocator_test;
  import dba_pkg::*;

  localparam logic [63:0] ADDR_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - ADDR_WIDTH);

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  dba_req_if in_req();
  dba_rsp_if out_rsp();

  double_ended_bump_allocator DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [DATA_W-1:0] heap_start_q;
  logic [DATA_W-1:0] heap_bytes_q;
  logic [DATA_W-1:0] head_cnt;
  logic [DATA_W-1:0] tail_cnt;

  dba_rsp_t outcomes_due[$];
  dba_rsp_t want;
  int       mismatches;
  int       burst_left;
  int       stall_mode = 0;
  int       mode_left = 0;
  int       stall_phase = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [63:0] bytes_free();
    logic [63:0] used;
    used = {32'd0, head_cnt} + {32'd0, tail_cnt};
    return (used > {32'd0, heap_bytes_q}) ? 64'd0 : {32'd0, heap_bytes_q} - used;
  endfunction

  function automatic dba_rsp_t allocator_outcome(dba_req_t r);
    logic [63:0]       region_end;
    logic [63:0]       head_addr;
    logic [63:0]       tail_addr;
    logic [63:0]       free_b;
    logic [63:0]       size;
    logic [63:0]       align;
    logic [63:0]       total;
    logic [63:0]       blk;
    logic [4:0]        lg;
    logic              fits;
    logic [DATA_W-1:0] ha;
    logic [DATA_W-1:0] ta;
    dba_rsp_t          o;
    o = '0;
    o.ok = 1'b1;
    if (r.cmd == CMD_ALLOC) begin
      region_end = {32'd0, heap_start_q} + {32'd0, heap_bytes_q};
      head_addr = {32'd0, heap_start_q} + {32'd0, head_cnt};
      tail_addr = region_end - {32'd0, tail_cnt};
      free_b = bytes_free();
      fits = !(region_end > 64'd0 && region_end - 64'd1 > ADDR_LIMIT);
      lg = (r.align_log2 < MIN_ALIGN) ? MIN_ALIGN : r.align_log2;
      align = 64'd1 << lg;
      size = (r.req_bytes < MIN_UNIT) ? {32'd0, MIN_UNIT} : {32'd0, r.req_bytes};
      size = (size + {32'd0, MIN_UNIT} - 64'd1) & ~({32'd0, MIN_UNIT} - 64'd1);
      if (!r.from_tail) begin
        blk = (head_addr + align - 64'd1) & ~(align - 64'd1);
        total = size + (blk - head_addr);
      end else if ({32'd0, tail_cnt} > region_end || size > tail_addr) begin
        fits = 1'b0;
        blk = 64'd0;
        total = 64'd0;
      end else begin
        blk = (tail_addr - size) & ~(align - 64'd1);
        total = tail_addr - blk;
      end
      if (fits && total <= free_b) begin
        o.block_addr = blk[31:0];
        if (!r.from_tail) begin
          head_cnt = head_cnt + total[31:0];
        end else begin
          tail_cnt = tail_cnt + total[31:0];
        end
      end else begin
        o.ok = 1'b0;
      end
    end else if (r.cmd == CMD_FREE_ALL) begin
      head_cnt = '0;
      tail_cnt = '0;
    end else if (r.cmd == CMD_FREE_TAIL) begin
      tail_cnt = '0;
    end
    ha = heap_start_q + head_cnt;
    ta = heap_start_q + heap_bytes_q - tail_cnt;
    free_b = bytes_free();
    o.free_bytes = free_b[31:0];
    o.head_used = head_cnt;
    o.tail_used = tail_cnt;
    o.check_code = ha + 32'd3 * ta;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch("result with nothing due", out_rsp.block_addr, '0);
      end else begin
        want = outcomes_due.pop_front();
        if (out_rsp.block_addr !== want.block_addr)
          report_mismatch("block_addr", out_rsp.block_addr, want.block_addr);
        if (out_rsp.ok !== want.ok)
          report_mismatch("ok", {31'd0, out_rsp.ok}, {31'd0, want.ok});
        if (out_rsp.free_bytes !== want.free_bytes)
          report_mismatch("free_bytes", out_rsp.free_bytes, want.free_bytes);
        if (out_rsp.head_used !== want.head_used)
          report_mismatch("head_used", out_rsp.head_used, want.head_used);
        if (out_rsp.tail_used !== want.tail_used)
          report_mismatch("tail_used", out_rsp.tail_used, want.tail_used);
        if (out_rsp.check_code !== want.check_code)
          report_mismatch("check_code", out_rsp.check_code, want.check_code);
      end
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(64, 256);
    end else begin
      mode_left--;
    end
    stall_phase++;
    case (stall_mode)
      0: out_rsp.ready <= 1'b1;
      1: out_rsp.ready <= 1'($urandom_range(0, 1));
      2: out_rsp.ready <= ($urandom_range(0, 3) == 0);
      default: out_rsp.ready <= (stall_phase % 3 != 0);
    endcase
  end

  task automatic send_request(logic [1:0] cmd, logic [31:0] bytes, logic [4:0] lg,
                              logic tail);
    int       gap;
    dba_req_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    r.cmd = cmd;
    r.req_bytes = bytes;
    r.align_log2 = lg;
    r.from_tail = tail;
    in_req.valid <= 1'b1;
    in_req.cmd <= cmd;
    in_req.req_bytes <= bytes;
    in_req.align_log2 <= lg;
    in_req.from_tail <= tail;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    outcomes_due.push_back(allocator_outcome(r));
    burst_left--;
  endtask

  task automatic wait_idle();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (outcomes_due.size() != 0);
  endtask

  task automatic cfg_write(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx == REG_HEAP_START) begin
      heap_start_q = value;
    end else begin
      heap_bytes_q = value;
    end
  endtask

  task automatic set_region(logic [31:0] start, logic [31:0] bytes);
    wait_idle();
    cfg_write(REG_HEAP_START, start);
    cfg_write(REG_HEAP_BYTES, bytes);
  endtask

  function automatic dba_req_t random_request();
    dba_req_t    r;
    int          pick;
    logic [31:0] span;
    pick = $urandom_range(0, 99);
    if (pick < 72) r.cmd = CMD_ALLOC;
    else if (pick < 80) r.cmd = CMD_FREE_ALL;
    else if (pick < 88) r.cmd = CMD_FREE_TAIL;
    else r.cmd = CMD_QUERY;
    span = heap_bytes_q >> 3;
    if (span < 32'd16) span = 32'd16;
    case ($urandom_range(0, 9))
      0: r.req_bytes = $urandom;
      1, 2: r.req_bytes = $urandom_range(0, 8);
      default: r.req_bytes = $urandom_range(0, span);
    endcase
    pick = $urandom_range(0, 19);
    if (pick == 0) r.align_log2 = 5'($urandom_range(0, 31));
    else if (pick < 4) r.align_log2 = 5'($urandom_range(0, 12));
    else r.align_log2 = 5'($urandom_range(0, 6));
    r.from_tail = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic test_reset_state();
    send_request(CMD_QUERY, 32'd0, 5'd0, 1'b0);
    send_request(CMD_ALLOC, 32'd0, 5'd0, 1'b0);
  endtask

  task automatic test_size_rounding();
    set_region(32'h0000_1000, 32'h0000_0100);
    send_request(CMD_ALLOC, 32'd0, 5'd0, 1'b0);
    send_request(CMD_ALLOC, 32'd1, 5'd1, 1'b0);
    send_request(CMD_ALLOC, 32'd5, 5'd2, 1'b0);
    send_request(CMD_ALLOC, 32'd4, 5'd4, 1'b0);
    send_request(CMD_ALLOC, 32'd3, 5'd0, 1'b1);
    send_request(CMD_ALLOC, 32'd6, 5'd4, 1'b1);
  endtask

  task automatic test_free_commands();
    send_request(CMD_FREE_TAIL, 32'd0, 5'd0, 1'b0);
    send_request(CMD_ALLOC, 32'd8, 5'd3, 1'b1);
    send_request(CMD_FREE_ALL, 32'hFFFF_FFFF, 5'd31, 1'b1);
    send_request(CMD_QUERY, 32'hFFFF_FFFF, 5'd31, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_request(CMD_ALLOC, 32'hFFFF_FFFF, 5'd31, 1'b0);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF, 5'd31, 1'b1);
    send_request(CMD_ALLOC, 32'h0000_0100, 5'd2, 1'b0);
    send_request(CMD_ALLOC, 32'd4, 5'd0, 1'b1);
    send_request(CMD_FREE_ALL, 32'd0, 5'd0, 1'b0);
  endtask

  task automatic test_tail_underflow();
    set_region(32'h0000_0000, 32'h0000_0010);
    send_request(CMD_ALLOC, 32'h0000_0020, 5'd2, 1'b1);
    send_request(CMD_ALLOC, 32'h0000_0010, 5'd2, 1'b1);
  endtask

  task automatic test_addr_overflow();
    set_region(32'hFFFF_FF00, 32'h0000_0200);
    send_request(CMD_ALLOC, 32'd4, 5'd2, 1'b0);
    send_request(CMD_ALLOC, 32'd4, 5'd2, 1'b1);
  endtask

  task automatic test_shrunk_region();
    set_region(32'h0000_1000, 32'h0000_0100);
    send_request(CMD_FREE_ALL, 32'd0, 5'd0, 1'b0);
    send_request(CMD_ALLOC, 32'h0000_0080, 5'd2, 1'b0);
    set_region(32'h0000_1000, 32'h0000_0040);
    send_request(CMD_QUERY, 32'd0, 5'd0, 1'b0);
    send_request(CMD_ALLOC, 32'd4, 5'd2, 1'b0);
    send_request(CMD_FREE_ALL, 32'd0, 5'd0, 1'b0);
    send_request(CMD_ALLOC, 32'd4, 5'd2, 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [31:0] starts[8];
    logic [31:0] sizes[8];
    dba_req_t    r;
    starts = '{32'h0000_1000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
               32'hFFFF_F000, 32'h0, 32'h1234_5678, 32'h0000_0003};
    sizes  = '{32'h0000_0400, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
               32'h0000_2000, 32'h0, 32'h0001_0000, 32'h0000_0101};
    starts[5] = $urandom;
    sizes[5] = $urandom_range(0, 32'h0001_0000);
    for (int p = 0; p < 8; p++) begin
      set_region(starts[p], sizes[p]);
      for (int i = 0; i < 220; i++) begin
        r = random_request();
        send_request(r.cmd, r.req_bytes, r.align_log2, r.from_tail);
      end
    end
  endtask

  initial begin
    int drain;
    mismatches = 0;
    burst_left = 0;
    heap_start_q = '0;
    heap_bytes_q = '0;
    head_cnt = '0;
    tail_cnt = '0;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_req.valid <= 1'b0;
    in_req.cmd <= CMD_QUERY;
    in_req.req_bytes <= '0;
    in_req.align_log2 <= '0;
    in_req.from_tail <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_size_rounding();
    test_free_commands();
    test_field_extremes();
    test_tail_underflow();
    test_addr_overflow();
    test_shrunk_region();
    test_random_traffic();

    in_req.valid <= 1'b0;
    drain = 0;
    while (outcomes_due.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);
    if (outcomes_due.size() != 0)
      report_mismatch("results never arrived", outcomes_due.size(), '0);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[double_ended_bump_allocator.f]
sv/dba_pkg.sv
sv/dba_if.sv
sv/dba_cfg_regs.sv
sv/dba_core.sv
sv/double_ended_bump_allocator.sv
tb/double_ended_bump_allocator_test.sv
